FILE: rtl/tli_pkg.sv
package tli_pkg;

	localparam int WORDS = 20;
	localparam int DEF_MAX_POINTS = 256;
	localparam int PADDR_W = 3;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_SEEN  = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	localparam logic REG_LOOK_AHEAD = 1'b0;
	localparam logic REG_TIMEOUT    = 1'b1;

	localparam logic [15:0] DEF_LOOK_AHEAD = 16'd200;
	localparam logic [31:0] DEF_TIMEOUT    = 32'd5000;

	localparam logic [4:0] W_TIME  = 5'd0;
	localparam logic [4:0] W_FIRST = 5'd1;
	localparam logic [4:0] W_QX    = 5'd4;
	localparam logic [4:0] W_QW    = 5'd7;
	localparam logic [4:0] W_LAST  = 5'd19;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam int DIV_RW = 34;
	localparam int DIV_DW = 33;
	localparam int DIV_QW = 31;
	localparam logic [4:0] ALPHA_STEPS = 5'd17;
	localparam logic [4:0] NORM_STEPS  = 5'd31;

	typedef struct packed {
		logic              start;
		logic [4:0]        steps;
		logic [DIV_RW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic              busy;
		logic [DIV_QW-1:0] quo;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/tli_if.sv
interface tli_item_if import tli_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [7:0]         point_slot;
	logic [4:0]         word_select;
	logic signed [31:0] word_value;
	logic [8:0]         point_total;
	logic [31:0]        now_ms;

	modport source (output valid, cmd, point_slot, word_select, word_value, point_total,
		now_ms, input ready);
	modport sink (input valid, cmd, point_slot, word_select, word_value, point_total,
		now_ms, output ready);
endinterface

interface tli_result_if import tli_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [4:0]         out_select;
	logic signed [31:0] out_value;
	logic               last_word;
	logic               at_end;

	modport source (output valid, out_select, out_value, last_word, at_end, input ready);
	modport sink (input valid, out_select, out_value, last_word, at_end, output ready);
endinterface

FILE: rtl/tli_div.sv
module tli_div import tli_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [DIV_RW-1:0] r_q;
	logic [DIV_DW-1:0] d_q;
	logic [DIV_QW-1:0] q_q;
	logic              ge;
	logic [DIV_RW-1:0] rs;

	// Restoring step: one quotient bit per cycle, remainder doubled after.
	always_comb begin
		ge = (r_q >= DIV_RW'(d_q));
		rs = ge ? DIV_RW'(r_q - DIV_RW'(d_q)) : r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= req.num;
			d_q <= req.den;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= {rs[DIV_RW-2:0], 1'b0};
			q_q <= {q_q[DIV_QW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quo  = q_q;

endmodule

FILE: rtl/trajectory_lookahead_interpolator.sv
// Trajectory look-ahead interpolator. Points are loaded one 32-bit word per
// transaction into an internal store of MAX_POINTS x 20 words. A tick that
// produces a reference point runs a sequencer around one shared multiplier, one
// iterative divider and a bit-serial square root: the segment search, times,
// alpha and the quaternion dot product, then, unless alpha is one, 16 slerp
// bisections (a square root and four normalizing divisions each), and then the
// output words in turn. A tick that returns the final point copies its stored
// words out. The input is ready only between items; the last result may still
// wait in the output register while the next item is taken. The store has no
// reset.
module trajectory_lookahead_interpolator import tli_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	tli_item_if.sink           item,
	tli_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int PW    = $clog2(MAX_POINTS);
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int DEPTH = MAX_POINTS * WORDS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [27:0] {
		S_IDLE    = 28'd1 << 0,
		S_SRCH_A  = 28'd1 << 1,
		S_SRCH_B  = 28'd1 << 2,
		S_T_A     = 28'd1 << 3,
		S_T_B     = 28'd1 << 4,
		S_T_C     = 28'd1 << 5,
		S_T_D     = 28'd1 << 6,
		S_ALPHA_W = 28'd1 << 7,
		S_Q_RD    = 28'd1 << 8,
		S_DOT     = 28'd1 << 9,
		S_DOT_FIN = 28'd1 << 10,
		S_BIS_H   = 28'd1 << 11,
		S_BIS_SS  = 28'd1 << 12,
		S_SQRT    = 28'd1 << 13,
		S_SQ_END  = 28'd1 << 14,
		S_DIV_GO  = 28'd1 << 15,
		S_DIV_W   = 28'd1 << 16,
		S_BIS_UPD = 28'd1 << 17,
		S_ROUTE   = 28'd1 << 18,
		S_LAST_A  = 28'd1 << 19,
		S_LAST_B  = 28'd1 << 20,
		S_Q_RES   = 28'd1 << 21,
		S_BL_A    = 28'd1 << 22,
		S_BL_B    = 28'd1 << 23,
		S_BL_C    = 28'd1 << 24,
		S_BL_D    = 28'd1 << 25,
		S_BL_E    = 28'd1 << 26,
		S_OUT_W   = 28'd1 << 27
	} state_t;

	state_t state_q;

	logic [15:0]        look_q;
	logic [31:0]        timeout_q;
	logic               tracking_q;
	logic               seen_q;
	logic [PW-1:0]      seg_q;
	logic [CW-1:0]      active_q;
	logic [31:0]        start_q;

	logic [32:0]        target_q;
	logic signed [31:0] t1_q;
	logic signed [34:0] num_q;
	logic signed [34:0] den_q;
	logic [16:0]        alpha_q;
	logic [3:0]         c_q;
	logic [4:0]         step_q;
	logic [3:0]         k_q;
	logic [4:0]         w_q;
	logic               at_end_q;

	logic signed [33:0] a_q [4];
	logic signed [33:0] b_q [4];
	logic signed [33:0] h_q [4];
	logic signed [33:0] m_q [4];
	logic signed [63:0] dot_q;
	logic [63:0]        n_q;
	logic [63:0]        r_q;
	logic [63:0]        bit_q;
	logic signed [31:0] v1_q;
	logic signed [31:0] v2_q;
	logic signed [67:0] p1_q;
	logic signed [31:0] res_q;
	logic signed [67:0] mul_q;

	logic               out_valid_q;
	logic [4:0]         out_sel_q;
	logic signed [31:0] out_val_q;
	logic               out_last_q;
	logic               out_end_q;

	logic [31:0]        mem [DEPTH];
	logic [31:0]        mem_rd_q;
	logic               mem_we;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic [PW-1:0]      rd_pt;
	logic [4:0]         rd_w;

	logic               in_acc;
	logic [31:0]        elapsed;
	logic [PW-1:0]      seg_nx;
	logic [1:0]         q_idx;
	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [63:0] prod;
	logic signed [63:0] pd;
	logic signed [34:0] nn;
	logic signed [34:0] dd;
	logic               alpha_div;
	logic signed [34:0] hs [4];
	logic signed [33:0] hv [4];
	logic signed [33:0] mm [4];
	logic [64:0]        sq_sum;
	logic signed [51:0] bl_s;
	logic [DIV_RW-1:0]  h_abs;
	logic               out_free;
	logic               cfg_we;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	tli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign item.ready = (state_q == S_IDLE);
	assign in_acc     = item.valid && item.ready;
	assign elapsed    = item.now_ms - start_q;
	assign seg_nx     = PW'(32'(seg_q) + 1);
	assign out_free   = !out_valid_q || result.ready;
	assign q_idx      = (state_q == S_Q_RES) ? 2'(w_q - W_QX) : c_q[1:0];

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			REG_LOOK_AHEAD: prdata = {16'd0, look_q};
			REG_TIMEOUT:    prdata = timeout_q;
			default:        prdata = '0;
		endcase
	end

	// Point store.
	assign mem_we  = in_acc && (item.cmd == CMD_LOAD) &&
		(32'(item.point_slot) < 32'(MAX_POINTS)) && (32'(item.word_select) < 32'(WORDS));
	assign wr_addr = AW'(32'(item.point_slot) * 32'(WORDS) + 32'(item.word_select));
	assign rd_addr = AW'(32'(rd_pt) * 32'(WORDS) + 32'(rd_w));

	always_comb begin
		rd_pt = seg_q;
		rd_w  = W_TIME;
		case (state_q)
			S_SRCH_A: rd_pt = seg_nx;
			S_T_B:    rd_pt = seg_nx;
			S_Q_RD: begin
				rd_pt = c_q[2] ? seg_nx : seg_q;
				rd_w  = W_QX + 5'(c_q[1:0]);
			end
			S_LAST_A: begin
				rd_pt = PW'(32'(active_q) - 1);
				rd_w  = w_q;
			end
			S_BL_A:   rd_w = w_q;
			S_BL_B: begin
				rd_pt = seg_nx;
				rd_w  = w_q;
			end
			default: begin
				rd_pt = seg_q;
				rd_w  = W_TIME;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= item.word_value;
		end
		mem_rd_q <= mem[rd_addr];
	end

	// Shared multiplier, one product per cycle.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_DOT: begin
				mul_a = a_q[q_idx];
				mul_b = b_q[q_idx];
			end
			S_BIS_SS: begin
				mul_a = h_q[q_idx];
				mul_b = h_q[q_idx];
			end
			S_BL_C: begin
				mul_a = $signed({17'd0, 17'(ONE_Q16 - alpha_q)});
				mul_b = 34'(v1_q);
			end
			S_BL_D: begin
				mul_a = $signed({17'd0, alpha_q});
				mul_b = 34'(v2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// Datapath helpers.
	always_comb begin
		prod = $signed(mul_q[63:0]);
		pd   = prod[63] ? ((prod + 64'sd3) >>> 2) : (prod >>> 2);
		nn   = den_q[34] ? -num_q : num_q;
		dd   = den_q[34] ? -den_q : den_q;
		alpha_div = (den_q != '0) && (nn > 35'sd0) && (nn < dd);
		for (int i = 0; i < 4; i++) begin
			hs[i] = 35'(a_q[i]) + 35'(b_q[i]);
			hv[i] = 34'((hs[i] + 35'(hs[i][34])) >>> 1);
			mm[i] = (r_q == '0) ? a_q[i] : m_q[i];
		end
		sq_sum = {1'b0, r_q} + {1'b0, bit_q};
		bl_s   = p1_q[51:0] + mul_q[51:0] + 52'sd32768;
		h_abs  = DIV_RW'(h_q[q_idx][33] ? -h_q[q_idx] : h_q[q_idx]);
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = NORM_STEPS;
		div_req.num   = h_abs;
		div_req.den   = DIV_DW'(r_q);
		if (state_q == S_T_D) begin
			div_req.start = alpha_div;
			div_req.steps = ALPHA_STEPS;
			div_req.num   = DIV_RW'(nn);
			div_req.den   = DIV_DW'(dd);
		end else if (state_q == S_DIV_GO) begin
			div_req.start = 1'b1;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			look_q      <= DEF_LOOK_AHEAD;
			timeout_q   <= DEF_TIMEOUT;
			tracking_q  <= 1'b0;
			seen_q      <= 1'b0;
			seg_q       <= '0;
			active_q    <= '0;
			start_q     <= '0;
			c_q         <= '0;
			step_q      <= '0;
			k_q         <= '0;
			w_q         <= W_FIRST;
			at_end_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (paddr[2])
					REG_LOOK_AHEAD: look_q <= pwdata[15:0];
					REG_TIMEOUT:    timeout_q <= pwdata;
					default:        look_q <= look_q;
				endcase
			end

			if (state_q == S_OUT_W && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (item.cmd)
							CMD_START: begin
								if (item.point_total != '0) begin
									active_q   <= (32'(item.point_total) > 32'(MAX_POINTS)) ?
										CW'(MAX_POINTS) : CW'(item.point_total);
									seg_q      <= '0;
									tracking_q <= 1'b1;
									start_q    <= item.now_ms;
								end
							end
							CMD_SEEN: seen_q <= 1'b1;
							CMD_TICK: begin
								if (tracking_q && seen_q && active_q != '0) begin
									if (elapsed > timeout_q) begin
										tracking_q <= 1'b0;
									end else if (32'(seg_q) + 1 >= 32'(active_q)) begin
										tracking_q <= 1'b0;
										at_end_q   <= 1'b1;
										w_q        <= W_FIRST;
										state_q    <= S_LAST_A;
									end else begin
										state_q <= S_SRCH_A;
									end
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SRCH_A: state_q <= S_SRCH_B;
				S_SRCH_B: begin
					if (35'($signed(mem_rd_q)) < $signed({2'b00, target_q})) begin
						seg_q <= seg_nx;
						if (32'(seg_q) + 2 >= 32'(active_q)) begin
							tracking_q <= 1'b0;
							at_end_q   <= 1'b1;
							w_q        <= W_FIRST;
							state_q    <= S_LAST_A;
						end else begin
							state_q <= S_SRCH_A;
						end
					end else begin
						state_q <= S_T_A;
					end
				end
				S_T_A: state_q <= S_T_B;
				S_T_B: state_q <= S_T_C;
				S_T_C: state_q <= S_T_D;
				S_T_D: begin
					c_q <= '0;
					state_q <= alpha_div ? S_ALPHA_W : S_Q_RD;
				end
				S_ALPHA_W: begin
					if (div_rsp.done) begin
						state_q <= S_Q_RD;
					end
				end
				S_Q_RD: begin
					if (c_q == 4'd8) begin
						c_q     <= '0;
						state_q <= S_DOT;
					end else begin
						c_q <= c_q + 4'd1;
					end
				end
				S_DOT: begin
					if (c_q == 4'd4) begin
						state_q <= S_DOT_FIN;
					end else begin
						c_q <= c_q + 4'd1;
					end
				end
				S_DOT_FIN: begin
					k_q <= 4'd15;
					if (alpha_q == ONE_Q16) begin
						at_end_q <= 1'b0;
						w_q      <= W_FIRST;
						state_q  <= S_ROUTE;
					end else begin
						state_q <= S_BIS_H;
					end
				end
				S_BIS_H: begin
					c_q     <= '0;
					step_q  <= '0;
					state_q <= S_BIS_SS;
				end
				S_BIS_SS: begin
					if (c_q == 4'd4) begin
						state_q <= S_SQRT;
					end else begin
						c_q <= c_q + 4'd1;
					end
				end
				S_SQRT: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						state_q <= S_SQ_END;
					end
				end
				S_SQ_END: begin
					c_q     <= '0;
					state_q <= (r_q == '0) ? S_BIS_UPD : S_DIV_GO;
				end
				S_DIV_GO: state_q <= S_DIV_W;
				S_DIV_W: begin
					if (div_rsp.done) begin
						if (c_q == 4'd3) begin
							state_q <= S_BIS_UPD;
						end else begin
							c_q     <= c_q + 4'd1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_BIS_UPD: begin
					if (k_q == '0) begin
						at_end_q <= 1'b0;
						w_q      <= W_FIRST;
						state_q  <= S_ROUTE;
					end else begin
						k_q     <= k_q - 4'd1;
						state_q <= S_BIS_H;
					end
				end
				S_ROUTE: begin
					if (at_end_q) begin
						state_q <= S_LAST_A;
					end else if (w_q inside {[W_QX:W_QW]}) begin
						state_q <= S_Q_RES;
					end else begin
						state_q <= S_BL_A;
					end
				end
				S_LAST_A: state_q <= S_LAST_B;
				S_LAST_B: state_q <= S_OUT_W;
				S_Q_RES:  state_q <= S_OUT_W;
				S_BL_A:   state_q <= S_BL_B;
				S_BL_B:   state_q <= S_BL_C;
				S_BL_C:   state_q <= S_BL_D;
				S_BL_D:   state_q <= S_BL_E;
				S_BL_E:   state_q <= S_OUT_W;
				S_OUT_W: begin
					if (out_free) begin
						if (w_q == W_LAST) begin
							state_q <= S_IDLE;
						end else begin
							w_q     <= w_q + 5'd1;
							state_q <= S_ROUTE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			target_q <= 33'(elapsed) + 33'(look_q);
		end
		case (state_q)
			S_T_B: t1_q <= $signed(mem_rd_q);
			S_T_C: begin
				num_q <= $signed({2'b00, target_q}) - 35'(t1_q);
				den_q <= 35'($signed(mem_rd_q)) - 35'(t1_q);
			end
			S_T_D: begin
				if (den_q == '0) begin
					alpha_q <= num_q[34] ? 17'd0 : ONE_Q16;
				end else if (nn <= 35'sd0) begin
					alpha_q <= 17'd0;
				end else if (nn >= dd) begin
					alpha_q <= ONE_Q16;
				end
			end
			S_ALPHA_W: begin
				if (div_rsp.done) begin
					alpha_q <= {1'b0, div_rsp.quo[15:0]};
				end
			end
			S_Q_RD: begin
				if (c_q != '0) begin
					if (c_q <= 4'd4) begin
						a_q[2'(c_q - 4'd1)] <= 34'($signed(mem_rd_q));
					end else begin
						b_q[2'(c_q - 4'd1)] <= 34'($signed(mem_rd_q));
					end
				end
				dot_q <= '0;
			end
			S_DOT: begin
				if (c_q != '0) begin
					dot_q <= dot_q + pd;
				end
			end
			S_DOT_FIN: begin
				// Shortest path: flip the far end when the dot product is negative.
				for (int i = 0; i < 4; i++) begin
					if (dot_q[63]) begin
						b_q[i] <= -b_q[i];
					end
					if (alpha_q == ONE_Q16) begin
						a_q[i] <= dot_q[63] ? -b_q[i] : b_q[i];
					end
				end
			end
			S_BIS_H: begin
				for (int i = 0; i < 4; i++) begin
					h_q[i] <= hv[i];
				end
				n_q   <= '0;
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
			end
			S_BIS_SS: begin
				if (c_q != '0) begin
					n_q <= n_q + mul_q[63:0];
				end
			end
			S_SQRT: begin
				if ({1'b0, n_q} >= sq_sum) begin
					n_q <= n_q - sq_sum[63:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIV_W: begin
				if (div_rsp.done) begin
					m_q[q_idx] <= h_q[q_idx][33] ? -34'(div_rsp.quo) : 34'(div_rsp.quo);
				end
			end
			S_BIS_UPD: begin
				for (int i = 0; i < 4; i++) begin
					if (alpha_q[k_q]) begin
						a_q[i] <= mm[i];
					end else begin
						b_q[i] <= mm[i];
					end
				end
			end
			S_LAST_B: res_q <= $signed(mem_rd_q);
			S_Q_RES:  res_q <= sat32(64'(a_q[q_idx]));
			S_BL_B:   v1_q <= $signed(mem_rd_q);
			S_BL_C:   v2_q <= $signed(mem_rd_q);
			S_BL_D:   p1_q <= mul_q;
			S_BL_E:   res_q <= sat32(64'(bl_s >>> 16));
			default:  res_q <= res_q;
		endcase
		if (state_q == S_OUT_W && out_free) begin
			out_sel_q  <= w_q;
			out_val_q  <= res_q;
			out_last_q <= (w_q == W_LAST);
			out_end_q  <= at_end_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_select = out_sel_q;
	assign result.out_value  = out_val_q;
	assign result.last_word  = out_last_q;
	assign result.at_end     = out_end_q;

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.last_word |-> result.out_select == W_LAST)
		else $error("last_word on a word other than the final one");

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		tracking_q |-> 32'(seg_q) < 32'(active_q))
		else $error("segment index beyond active points");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == S_ALPHA_W || state_q == S_DIV_W))
		else $error("divider running while sequencer is not waiting on it");

endmodule

FILE: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tli_pkg::*;

	localparam int NPTS         = DEF_MAX_POINTS;
	localparam int WATCH_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 3200;
	localparam int HOLD_CYCLES  = 4000;
	localparam logic [31:0] TIMEOUT_MAX = 32'd4000000000;

	typedef struct {
		logic [4:0]         sel;
		logic signed [31:0] val;
		logic               lw;
		logic               ae;
	} ref_word_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	tli_item_if   item_bus ();
	tli_result_if res_bus ();

	trajectory_lookahead_interpolator #(
		.MAX_POINTS(NPTS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (res_bus),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Shadow copy of the block's state.
	logic [31:0] point_tbl [NPTS*WORDS];
	int unsigned seg_idx;
	int unsigned act_pts;
	bit          trk_on;
	bit          seen_on;
	logic [31:0] t_start;
	logic [15:0] la_ms;
	logic [31:0] to_ms;

	ref_word_t pending_words [$];
	int errors;
	int mode;
	int hold_req;
	int hold_done;
	int hold_cnt;
	int idle_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint tw(int unsigned pt, int unsigned w);
		return longint'($signed(point_tbl[pt*WORDS+w]));
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint blend_q16(longint v1, longint v2, longint alpha);
		longint s;
		s = (65536 - alpha) * v1 + alpha * v2 + 32768;
		return s >>> 16;
	endfunction

	function automatic void push_word(int unsigned w, longint v, bit ae);
		ref_word_t e;
		e.sel = w;
		e.val = clamp32(v);
		e.lw  = (w == W_LAST);
		e.ae  = ae;
		pending_words.push_back(e);
	endfunction

	function automatic void push_last_point();
		int unsigned w;
		for (w = W_FIRST; w <= W_LAST; w++) push_word(w, tw(act_pts - 1, w), 1'b1);
		trk_on = 1'b0;
	endfunction

	function automatic void interp_accept(logic [1:0] c, logic [7:0] slot, logic [4:0] wsel,
			logic [31:0] wval, logic [8:0] total, logic [31:0] now);
		logic [31:0]     elapsed;
		longint          target, t1, t2, num, den, alpha, dot;
		longint          qa [4];
		longint          qb [4];
		longint          qh [4];
		longint          qm [4];
		longint unsigned ss, nrm;
		int              i, k;
		int unsigned     w;
		case (c)
			CMD_LOAD: begin
				if (wsel < WORDS) point_tbl[slot*WORDS+wsel] = wval;
				return;
			end
			CMD_START: begin
				if (total == 0) return;
				act_pts = (total > NPTS) ? NPTS : total;
				seg_idx = 0;
				trk_on  = 1'b1;
				t_start = now;
				return;
			end
			CMD_SEEN: begin
				seen_on = 1'b1;
				return;
			end
			default: ;
		endcase
		if (!trk_on || !seen_on || act_pts == 0) return;
		elapsed = now - t_start;
		if (elapsed > to_ms) begin
			trk_on = 1'b0;
			return;
		end
		target = longint'(elapsed) + longint'(la_ms);
		if (seg_idx + 1 >= act_pts) begin
			push_last_point();
			return;
		end
		while (seg_idx + 1 < act_pts && tw(seg_idx + 1, W_TIME) < target) seg_idx++;
		if (seg_idx + 1 >= act_pts) begin
			push_last_point();
			return;
		end
		t1 = tw(seg_idx, W_TIME);
		t2 = tw(seg_idx + 1, W_TIME);
		num = target - t1;
		den = t2 - t1;
		if (den == 0) begin
			alpha = (num >= 0) ? 65536 : 0;
		end else begin
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			if (num <= 0) alpha = 0;
			else if (num >= den) alpha = 65536;
			else alpha = (num * 65536) / den;
		end
		// Shortest-path slerp by repeated arc bisection, one step per alpha bit.
		dot = 0;
		for (i = 0; i < 4; i++) dot += (tw(seg_idx, W_QX + i) * tw(seg_idx + 1, W_QX + i)) / 4;
		for (i = 0; i < 4; i++) begin
			qa[i] = tw(seg_idx, W_QX + i);
			qb[i] = (dot < 0) ? -tw(seg_idx + 1, W_QX + i) : tw(seg_idx + 1, W_QX + i);
		end
		if (alpha >= 65536) begin
			qa = qb;
		end else begin
			for (k = 15; k >= 0; k--) begin
				ss = 0;
				for (i = 0; i < 4; i++) begin
					qh[i] = (qa[i] + qb[i]) / 2;
					ss += longint'(qh[i] * qh[i]);
				end
				nrm = root64(ss);
				if (nrm == 0) begin
					qm = qa;
				end else begin
					for (i = 0; i < 4; i++) qm[i] = (qh[i] * (64'sd1 <<< 30)) / longint'(nrm);
				end
				if (alpha[k]) qa = qm;
				else qb = qm;
			end
		end
		for (w = W_FIRST; w <= W_LAST; w++) begin
			if (w >= W_QX && w <= W_QW) push_word(w, qa[w - W_QX], 1'b0);
			else push_word(w, blend_q16(tw(seg_idx, w), tw(seg_idx + 1, w), alpha), 1'b0);
		end
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_quat_word();
		if ($urandom_range(0, 3) == 0) return rand_word();
		return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
	endfunction

	function automatic bit sender_rests();
		case (mode)
			0: return $urandom_range(0, 99) < 25;
			1: return $urandom_range(0, 99) < 57;
			default: return 1'b0;
		endcase
	endfunction

	// Result acceptance and comparison.
	always @(posedge clk) begin
		ref_word_t e;
		if (arst_n === 1'b1 && res_bus.valid && res_bus.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t unexpected result: out_select %0d out_value %h", $time,
					res_bus.out_select, res_bus.out_value);
				errors++;
			end else begin
				e = pending_words.pop_front();
				if (res_bus.out_select !== e.sel) begin
					$display("%0t out_select mismatch: expected %0d actual %0d", $time, e.sel,
						res_bus.out_select);
					errors++;
				end
				if (res_bus.out_value !== e.val) begin
					$display("%0t out_value mismatch (word %0d): expected %h actual %h", $time,
						e.sel, e.val, res_bus.out_value);
					errors++;
				end
				if (res_bus.last_word !== e.lw) begin
					$display("%0t last_word mismatch (word %0d): expected %b actual %b", $time,
						e.sel, e.lw, res_bus.last_word);
					errors++;
				end
				if (res_bus.at_end !== e.ae) begin
					$display("%0t at_end mismatch (word %0d): expected %b actual %b", $time,
						e.sel, e.ae, res_bus.at_end);
					errors++;
				end
			end
		end
	end

	// Receiver side: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_cnt == 0 && hold_req != hold_done) begin
			hold_done = hold_req;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_bus.ready <= 1'b0;
		end else begin
			case (mode)
				0: res_bus.ready <= $urandom_range(0, 99) >= 57;
				1: res_bus.ready <= $urandom_range(0, 99) >= 25;
				default: res_bus.ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("%0t watchdog: no transaction for %0d cycles", $time, WATCH_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] c, logic [7:0] slot, logic [4:0] wsel,
			logic [31:0] wval, logic [8:0] total, logic [31:0] now);
		@(negedge clk);
		while (sender_rests()) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid       <= 1'b1;
		item_bus.cmd         <= c;
		item_bus.point_slot  <= slot;
		item_bus.word_select <= wsel;
		item_bus.word_value  <= wval;
		item_bus.point_total <= total;
		item_bus.now_ms      <= now;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		interp_accept(c, slot, wsel, wval, total, now);
	endtask

	task automatic load_word(int unsigned slot, int unsigned w, logic [31:0] v);
		send_item(CMD_LOAD, slot, w, v, $urandom, $urandom);
	endtask

	task automatic load_point(int unsigned slot, logic [31:0] t);
		int unsigned w;
		load_word(slot, W_TIME, t);
		for (w = W_FIRST; w <= W_LAST; w++) begin
			load_word(slot, w, (w >= W_QX && w <= W_QW) ? rand_quat_word() : rand_word());
		end
	endtask

	task automatic start_run(logic [8:0] total, logic [31:0] now);
		send_item(CMD_START, $urandom, $urandom, $urandom, total, now);
	endtask

	task automatic tick(logic [31:0] now);
		send_item(CMD_TICK, $urandom, $urandom, $urandom, $urandom, now);
	endtask

	task automatic state_report();
		send_item(CMD_SEEN, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic r, logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (r == REG_LOOK_AHEAD) la_ms = v[15:0];
		else to_ms = v;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_check(logic r, logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {r, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== v) begin
			$display("%0t register %0d read mismatch: expected %h actual %h", $time, r, v,
				prdata);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_regs(logic [15:0] la, logic [31:0] to);
		settle();
		reg_write(REG_LOOK_AHEAD, la);
		reg_write(REG_TIMEOUT, to);
		reg_check(REG_LOOK_AHEAD, 32'(la));
		reg_check(REG_TIMEOUT, to);
	endtask

	task automatic test_register_reset();
		reg_check(REG_LOOK_AHEAD, 32'(DEF_LOOK_AHEAD));
		reg_check(REG_TIMEOUT, DEF_TIMEOUT);
	endtask

	task automatic test_edge_cases();
		int i;
		mode = 0;
		tick(123);
		load_point(0, 500);
		load_point(1, 500);
		load_point(2, 1500);
		load_point(3, 1000);
		load_word(0, W_FIRST, 32'h7fffffff);
		load_word(1, W_FIRST, 32'h80000000);
		// Opposite quaternions force the negated-endpoint path.
		for (i = 0; i < 4; i++) begin
			load_word(0, W_QX + i, (i == 0) ? 32'h4000_0000 : 32'h0);
			load_word(1, W_QX + i, (i == 0) ? 32'hc000_0000 : 32'h0);
		end
		load_word(0, 20, $urandom);
		load_word(3, 31, $urandom);
		start_run(0, 7);
		tick(10);
		set_regs(0, TIMEOUT_MAX);
		start_run(4, 1000);
		tick(1400);
		state_report();
		tick(1400);
		tick(1500);
		tick(2000);
		tick(2499);
		tick(2600);
		tick(2700);
		// Zero quaternions give a zero midpoint norm; start time wraps past 2^32.
		for (i = 0; i < 4; i++) begin
			load_word(0, W_QX + i, 32'h0);
			load_word(1, W_QX + i, 32'h0);
		end
		load_word(0, W_TIME, 300);
		load_word(1, W_TIME, 800);
		start_run(2, 32'hffff_ff00);
		tick(32'h0000_0010);
		tick(32'h0000_0100);
		// Falling segment times with a zero timeout.
		set_regs(0, 0);
		load_word(0, W_TIME, 800);
		load_word(1, W_TIME, 300);
		start_run(2, 5000);
		tick(5000);
		tick(5001);
		tick(5002);
		set_regs(60000, TIMEOUT_MAX);
		start_run(2, 0);
		tick(0);
	endtask

	task automatic test_random_trajectories();
		int tr, n, i, span, tcur, r;
		logic [31:0] s_now, el;
		for (tr = 0; tr < 20; tr++) begin
			mode = tr / 7;
			if (tr % 5 == 0) begin
				case (tr / 5)
					0: set_regs(100, TIMEOUT_MAX);
					1: set_regs(0, 3000);
					2: set_regs(60000, TIMEOUT_MAX);
					default: set_regs($urandom_range(0, 400), $urandom_range(500, 5000));
				endcase
			end
			if (tr == 0) begin
				for (i = 0; i < 6; i++) load_point(i, 0);
			end
			n = $urandom_range(2, 6);
			tcur = ($urandom_range(0, 4) == 0) ? -$urandom_range(0, 200) : $urandom_range(0, 300);
			span = 0;
			for (i = 0; i < n; i++) begin
				load_word(i, W_TIME, tcur);
				if (tcur > span) span = tcur;
				r = $urandom_range(0, 9);
				if (r == 0) tcur = tcur;
				else if (r == 1) tcur = tcur - $urandom_range(1, 200);
				else tcur = tcur + $urandom_range(1, 500);
			end
			repeat (5) begin
				i = $urandom_range(W_FIRST, W_LAST);
				load_word($urandom_range(0, n - 1), i,
					(i >= W_QX && i <= W_QW) ? rand_quat_word() : rand_word());
			end
			case ($urandom_range(0, 3))
				0: load_word($urandom_range(0, 255), $urandom_range(WORDS, 31), $urandom);
				1: state_report();
				2: start_run(0, $urandom);
				default: ;
			endcase
			s_now = $urandom;
			start_run(n, s_now);
			// Hold the receiver off while ticks keep coming, so the block backs up.
			if (tr == 3) hold_req = hold_req + 1;
			if (tr == 10) wait_drained();
			repeat (6) begin
				el = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, span + 500);
				tick(s_now + el);
			end
		end
	endtask

	task automatic test_full_table();
		int slot;
		mode = 0;
		set_regs(0, TIMEOUT_MAX);
		for (slot = 0; slot < NPTS; slot++) load_point(slot, slot * 10);
		start_run(300, 0);
		tick(5);
		tick(1275);
		tick(2549);
		tick(3000);
		start_run(511, 100);
		tick(2100);
		start_run(200, 7);
		tick(1997);
		tick(5007);
	endtask

	initial begin
		errors      = 0;
		mode        = 2;
		hold_req    = 0;
		hold_done   = 0;
		hold_cnt    = 0;
		idle_cycles = 0;
		seg_idx     = 0;
		act_pts     = 0;
		trk_on      = 1'b0;
		seen_on     = 1'b0;
		t_start     = '0;
		la_ms       = DEF_LOOK_AHEAD;
		to_ms       = DEF_TIMEOUT;
		foreach (point_tbl[i]) point_tbl[i] = '0;
		item_bus.valid       = 1'b0;
		item_bus.cmd         = CMD_LOAD;
		item_bus.point_slot  = '0;
		item_bus.word_select = '0;
		item_bus.word_value  = '0;
		item_bus.point_total = '0;
		item_bus.now_ms      = '0;
		res_bus.ready        = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		arst_n               = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_reset();
		test_edge_cases();
		test_random_trajectories();
		test_full_table();
		mode = 2;
		settle();
		if (pending_words.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time, pending_words.size());
			errors++;
		end
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
